// ===== hw/rtl/ece_pkg.sv =====
package ece_pkg;

	// Beat field widths
	localparam int unsigned PROG_W = 18;
	localparam int unsigned KIND_W = 4;
	localparam int unsigned EASED_W = 18;

	// Curve select codes; every other code evaluates as linear
	typedef enum logic [KIND_W-1:0] {
		KIND_LINEAR      = 4'd0,
		KIND_QUAD_IN     = 4'd1,
		KIND_QUAD_OUT    = 4'd2,
		KIND_QUAD_INOUT  = 4'd3,
		KIND_CUBIC_IN    = 4'd4,
		KIND_CUBIC_OUT   = 4'd5,
		KIND_CUBIC_INOUT = 4'd6,
		KIND_QUART_IN    = 4'd7,
		KIND_QUART_OUT   = 4'd8,
		KIND_BACK_BEZIER = 4'd12
	} kind_t;

endpackage

// ===== hw/rtl/easing_curve_evaluator.sv =====
// An accepted input beat is registered in stages 1 to 6 in turn; stage 6 drives eased/out_valid.
// Throughput: one beat per cycle unless the output stalls; the rate is set by the six-stage
// pipeline, with one product stage per step of the longest multiply chain (three in a row).
// A stalled output holds only the full stages; bubbles ahead of it still fill.
// Reset (arst_n low) clears every stage valid bit; data registers are not reset.
module easing_curve_evaluator
	import ece_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [PROG_W-1:0]   progress,
	input  logic        [KIND_W-1:0]   kind,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [EASED_W-1:0]  eased
);

	// Operand width covers [-8.0, 8.0) with FRAC_BITS fraction bits
	localparam int unsigned W  = FRAC_BITS + 4;
	localparam int unsigned CW = FRAC_BITS + PROG_W + 2;
	localparam int unsigned SW = W + EASED_W;

	localparam logic signed [CW-1:0] ONE_C   = CW'(64'd1 << FRAC_BITS);
	localparam logic signed [W-1:0]  ONE_W   = W'(64'd1 << FRAC_BITS);
	localparam logic [FRAC_BITS:0]   HALF_T  = (FRAC_BITS+1)'(64'd1 << (FRAC_BITS - 1));
	localparam logic signed [W-1:0]  Y1      =
		-W'(((64'd55 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic signed [W-1:0]  Y2      =
		W'(((64'd155 << FRAC_BITS) + 64'd50) / 64'd100);

	// Fixed-point product, floored to FRAC_BITS fraction bits
	function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [2*W-1:0] p;
		p = a * b;
		return W'(p >>> FRAC_BITS);
	endfunction

	// Stage valid bits and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic go1, go2, go3, go4, go5, go6;

	assign go6 = !v_s6 || out_ready;
	assign go5 = !v_s5 || go6;
	assign go4 = !v_s4 || go5;
	assign go3 = !v_s3 || go4;
	assign go2 = !v_s2 || go3;
	assign go1 = !v_s1 || go2;
	assign in_ready = go1;
	assign out_valid = v_s6;

	// Stage 1: clamp progress to [0, ONE]
	logic signed [CW-1:0]  prog_x;
	logic [FRAC_BITS:0]    t_clamp;
	logic [FRAC_BITS:0]    t_s1;
	logic [KIND_W-1:0]     kind_s1;

	always_comb begin
		prog_x = CW'(progress);
		if (prog_x[CW-1]) begin
			t_clamp = '0;
		end else if (prog_x > ONE_C) begin
			t_clamp = (FRAC_BITS+1)'(ONE_C);
		end else begin
			t_clamp = prog_x[FRAC_BITS:0];
		end
	end

	// Stage 2: pick the multiply chain operands per curve
	logic signed [W-1:0] t_w, u_w, d_w;
	logic signed [W-1:0] ax_c, ay_c, aq1_c, aq2_c, off_c;
	logic                neg_c, bez_c;

	logic signed [W-1:0] ax_s2, ay_s2, aq1_s2, aq2_s2, off_s2;
	logic signed [W-1:0] bx_s2, by_s2, cy_s2, t_s2;
	logic                neg_s2, bez_s2;

	always_comb begin
		t_w   = $signed({3'b000, t_s1});
		u_w   = ONE_W - t_w;
		d_w   = (t_w <<< 1) - (ONE_W <<< 1);
		ax_c  = t_w;
		ay_c  = ONE_W;
		aq1_c = ONE_W;
		aq2_c = ONE_W;
		off_c = '0;
		neg_c = 1'b0;
		bez_c = 1'b0;
		case (kind_s1)
			KIND_QUAD_IN: begin
				ay_c = t_w;
			end
			KIND_QUAD_OUT: begin
				ay_c = (ONE_W <<< 1) - t_w;
			end
			KIND_QUAD_INOUT: begin
				ay_c = t_w;
				if (t_s1 < HALF_T) begin
					ax_c = t_w <<< 1;
				end else begin
					ax_c  = (ONE_W <<< 2) - (t_w <<< 1);
					off_c = -ONE_W;
				end
			end
			KIND_CUBIC_IN: begin
				ay_c  = t_w;
				aq1_c = t_w;
			end
			KIND_CUBIC_OUT: begin
				ax_c  = u_w;
				ay_c  = u_w;
				aq1_c = u_w;
				off_c = ONE_W;
				neg_c = 1'b1;
			end
			KIND_CUBIC_INOUT: begin
				if (t_s1 < HALF_T) begin
					ax_c  = t_w <<< 2;
					ay_c  = t_w;
					aq1_c = t_w;
				end else begin
					ax_c  = t_w - ONE_W;
					ay_c  = d_w;
					aq1_c = d_w;
					off_c = ONE_W;
				end
			end
			KIND_QUART_IN: begin
				ay_c  = t_w;
				aq1_c = t_w;
				aq2_c = t_w;
			end
			KIND_QUART_OUT: begin
				ax_c  = u_w;
				ay_c  = u_w;
				aq1_c = u_w;
				aq2_c = u_w;
				off_c = ONE_W;
				neg_c = 1'b1;
			end
			KIND_BACK_BEZIER: begin
				ay_c  = t_w;
				aq1_c = t_w;
				bez_c = 1'b1;
			end
			default: begin
				ax_c = t_w;
			end
		endcase
	end

	// Stages 3..5: three product steps per lane; lane A is the curve chain,
	// lanes B and C carry the two Bezier control-point terms
	logic signed [W-1:0] a_s3, aq1_s3, aq2_s3, b_s3, c_s3, t_s3, off_s3;
	logic                neg_s3, bez_s3;
	logic signed [W-1:0] a_s4, aq2_s4, b_s4, c_s4, off_s4;
	logic                neg_s4, bez_s4;
	logic signed [W-1:0] a_s5, b_s5, c_s5, off_s5;
	logic                neg_s5, bez_s5;

	// Stage 6: combine offset, sign and Bezier terms into the result
	logic signed [SW-1:0]      sum_c;
	logic signed [EASED_W-1:0] eased_s6;

	always_comb begin
		sum_c = SW'(off_s5) + (neg_s5 ? -SW'(a_s5) : SW'(a_s5));
		if (bez_s5) begin
			sum_c = sum_c + SW'(b_s5) + SW'(c_s5);
		end
	end

	assign eased = eased_s6;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (go1) v_s1 <= in_valid;
			if (go2) v_s2 <= v_s1;
			if (go3) v_s3 <= v_s2;
			if (go4) v_s4 <= v_s3;
			if (go5) v_s5 <= v_s4;
			if (go6) v_s6 <= v_s5;
		end
	end

	// Advance data; a stalled stage holds its beat
	always_ff @(posedge clk) begin
		if (go1) begin
			t_s1    <= t_clamp;
			kind_s1 <= kind;
		end
		if (go2) begin
			ax_s2  <= ax_c;
			ay_s2  <= ay_c;
			aq1_s2 <= aq1_c;
			aq2_s2 <= aq2_c;
			off_s2 <= off_c;
			neg_s2 <= neg_c;
			bez_s2 <= bez_c;
			bx_s2  <= (u_w <<< 1) + u_w;
			by_s2  <= u_w;
			cy_s2  <= t_w;
			t_s2   <= t_w;
		end
		if (go3) begin
			a_s3   <= fmul(ax_s2, ay_s2);
			b_s3   <= fmul(bx_s2, by_s2);
			c_s3   <= fmul(bx_s2, cy_s2);
			aq1_s3 <= aq1_s2;
			aq2_s3 <= aq2_s2;
			t_s3   <= t_s2;
			off_s3 <= off_s2;
			neg_s3 <= neg_s2;
			bez_s3 <= bez_s2;
		end
		if (go4) begin
			a_s4   <= fmul(a_s3, aq1_s3);
			b_s4   <= fmul(b_s3, t_s3);
			c_s4   <= fmul(c_s3, t_s3);
			aq2_s4 <= aq2_s3;
			off_s4 <= off_s3;
			neg_s4 <= neg_s3;
			bez_s4 <= bez_s3;
		end
		if (go5) begin
			a_s5   <= fmul(a_s4, aq2_s4);
			b_s5   <= fmul(b_s4, Y1);
			c_s5   <= fmul(c_s4, Y2);
			off_s5 <= off_s4;
			neg_s5 <= neg_s4;
			bez_s5 <= bez_s4;
		end
		if (go6) begin
			eased_s6 <= EASED_W'(sum_c);
		end
	end

	// An accepted beat lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted beat missing from stage 1");

	// Input stalls only when every stage holds a beat
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6)
		else $error("input stalled with a bubble in the pipeline");

	// A blocked product stage keeps its beat and value
	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !go3 |=> v_s3 && $stable(a_s3) && $stable(b_s3) && $stable(c_s3))
		else $error("stage 3 changed while stalled");

	// A blocked last product stage keeps its beat
	a_s5_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !go5 |=> v_s5 && $stable(a_s5) && $stable(off_s5))
		else $error("stage 5 changed while stalled");

endmodule
